@@ rtl/core/frs_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// frs_pkg
// Types, codes and helpers shared by the fragment reassembly slot table.
// ---------------------------------------------------------------------------
package frs_pkg;

  localparam int SLOT_COUNT      = 4;
  localparam int FRAG_HEADER_LEN = 3;
  localparam int CFG_ADDR_W      = 4;

  // first byte codes
  localparam logic [7:0] CHAR_WHOLE = 8'h74;   // 't'
  localparam logic [5:0] FRAG_MARK  = 6'h20;   // upper six bits of 0x80
  localparam logic [1:0] PART_ONE   = 2'd1;
  localparam logic [1:0] PART_TWO   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_WHOLE  = 3'd0;
  localparam logic [2:0] ST_STORED = 3'd1;
  localparam logic [2:0] ST_JOINED = 3'd2;
  localparam logic [2:0] ST_SHAPE  = 3'd3;
  localparam logic [2:0] ST_LONG   = 3'd4;
  localparam logic [2:0] ST_EMPTY  = 3'd5;

  // register indexes
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_MAX_MSG  = 2'd2;
  localparam logic [1:0] REG_MAX_FRAG = 2'd3;

  localparam logic [30:0] RST_TIMEOUT  = 31'd30000;
  localparam logic [9:0]  RST_CAPACITY = 10'd512;
  localparam logic [8:0]  RST_MAX_MSG  = 9'd400;
  localparam logic [7:0]  RST_MAX_FRAG = 8'd200;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  byte_count;
    logic [31:0] sender_node;
    logic [15:0] pair_tag;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_index;
    logic       part_index;
    logic [7:0] first_part_len;
    logic [8:0] total_len;
  } out_word_t;

  typedef struct packed {
    logic [30:0] fragment_timeout_ms;
    logic [9:0]  output_capacity;
    logic [8:0]  max_message_len;
    logic [7:0]  max_fragment_data;
  } cfg_t;

  // one slot as seen by the scan unit, plus the running spare and the key
  typedef struct packed {
    logic        first;
    logic        busy;
    logic [31:0] sender;
    logic [15:0] tag;
    logic [31:0] start;
    logic        spare_busy;
    logic [31:0] spare_start;
    logic [31:0] key_sender;
    logic [15:0] key_tag;
    logic [31:0] now;
  } scan_in_t;

  typedef struct packed {
    logic expire;
    logic busy_after;
    logic hit;
    logic take_spare;
  } scan_res_t;

  // message must fit capacity minus terminator and the message limit
  function automatic logic too_long(logic [8:0] n, logic [9:0] cap, logic [8:0] max_len);
    return ({1'b0, n} >= cap) || (n > max_len);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fragment_reassembly_slots.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// fragment_reassembly_slots
// Pairs two-part fragments by sender and tag in a small slot table.
// Empty, whole and malformed words: result valid in the cycle after acceptance.
// Fragments: one slot per cycle through the scan unit, then an update state;
// the result is registered in the update state, and the input stays stalled
// until the sequencer is back in idle.
// Reset empties the table and loads default limits; no clearing pass.
// ---------------------------------------------------------------------------
module fragment_reassembly_slots #(
  parameter int SLOT_COUNT = frs_pkg::SLOT_COUNT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  frs_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output frs_pkg::out_word_t              out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import frs_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  cfg_t cfg;

  frs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // slot table
  logic        busy_q   [SLOT_COUNT];
  logic [31:0] sender_q [SLOT_COUNT];
  logic [15:0] tag_q    [SLOT_COUNT];
  logic [31:0] start_q  [SLOT_COUNT];
  logic [1:0]  have_q   [SLOT_COUNT];
  logic [7:0]  len1_q   [SLOT_COUNT];
  logic [7:0]  len2_q   [SLOT_COUNT];

  logic [1:0]        state_q, state_d;
  logic [SLOT_W-1:0] idx_q;
  in_word_t          item_q;
  logic              part_q;      // 0 part one, 1 part two
  logic [7:0]        n_q;
  logic              match_v_q;
  logic [SLOT_W-1:0] match_q;
  logic [SLOT_W-1:0] spare_q;
  logic              spare_busy_q;
  logic [31:0]       spare_start_q;
  logic [1:0]        have_m_q;
  logic [7:0]        len1_m_q;
  logic [7:0]        len2_m_q;
  logic              out_valid_q;
  out_word_t         out_q;

  // ---------------- accept and classify ----------------
  logic      in_acc;
  logic [7:0] dlen;
  logic      is_frag;
  out_word_t quick;

  assign in_stall_o = (state_q != S_IDLE) | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign dlen       = in_data_i.byte_count - 8'(FRAG_HEADER_LEN);

  always_comb begin
    quick   = '0;
    is_frag = 1'b0;
    if (in_data_i.byte_count == 8'd0) begin
      quick.status = ST_EMPTY;
    end else if (in_data_i.first_byte == CHAR_WHOLE) begin
      quick.total_len = {1'b0, in_data_i.byte_count};
      quick.status = too_long({1'b0, in_data_i.byte_count}, cfg.output_capacity,
                              cfg.max_message_len) ? ST_LONG : ST_WHOLE;
    end else if ((in_data_i.first_byte[7:2] == FRAG_MARK) &&
                 ((in_data_i.first_byte[1:0] == PART_ONE) ||
                  (in_data_i.first_byte[1:0] == PART_TWO)) &&
                 (in_data_i.byte_count > 8'(FRAG_HEADER_LEN)) &&
                 (dlen <= cfg.max_fragment_data)) begin
      is_frag = 1'b1;
    end else begin
      quick.status = ST_SHAPE;
    end
  end

  // ---------------- shared scan unit ----------------
  scan_in_t  sv;
  scan_res_t sr;
  logic      scan_last;

  always_comb begin
    sv.first       = (idx_q == '0);
    sv.busy        = busy_q[idx_q];
    sv.sender      = sender_q[idx_q];
    sv.tag         = tag_q[idx_q];
    sv.start       = start_q[idx_q];
    sv.spare_busy  = spare_busy_q;
    sv.spare_start = spare_start_q;
    sv.key_sender  = item_q.sender_node;
    sv.key_tag     = item_q.pair_tag;
    sv.now         = item_q.now_ms;
  end

  frs_scan_unit u_scan (
    .slot_i    (sv),
    .timeout_i (cfg.fragment_timeout_ms),
    .res_o     (sr)
  );

  assign scan_last = (idx_q == SLOT_W'(SLOT_COUNT - 1));

  // ---------------- slot update ----------------
  logic [SLOT_W-1:0] s_idx;
  logic [1:0]        have_new;
  logic [7:0]        p1, p2;
  logic              joined;
  logic [8:0]        total;
  out_word_t         upd;

  always_comb begin
    s_idx    = match_v_q ? match_q : spare_q;
    have_new = (match_v_q ? have_m_q : 2'b00) | (part_q ? 2'b10 : 2'b01);
    p1       = part_q ? (match_v_q ? len1_m_q : 8'd0) : n_q;
    p2       = part_q ? n_q : (match_v_q ? len2_m_q : 8'd0);
    joined   = &have_new;
    total    = {1'b0, p1} + {1'b0, p2};
    upd                = '0;
    upd.slot_index     = 4'(s_idx);
    upd.part_index     = part_q;
    upd.first_part_len = p1;
    if (joined) begin
      upd.total_len = total;
      upd.status = too_long(total, cfg.output_capacity, cfg.max_message_len)
                   ? ST_LONG : ST_JOINED;
    end else begin
      upd.status = ST_STORED;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && is_frag) state_d = S_SCAN;
      S_SCAN:   if (scan_last) state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      match_v_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) busy_q[i] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (in_acc) begin
        idx_q     <= '0;
        match_v_q <= 1'b0;
        if (!is_frag) out_valid_q <= 1'b1;
      end
      if (state_q == S_SCAN) begin
        idx_q <= idx_q + SLOT_W'(1);
        if (sr.expire) busy_q[idx_q] <= 1'b0;
        if (sr.hit) match_v_q <= 1'b1;
      end
      if (state_q == S_UPDATE) begin
        busy_q[s_idx] <= ~joined;
        out_valid_q   <= 1'b1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
      part_q <= (in_data_i.first_byte[1:0] == PART_TWO);
      n_q    <= dlen;
      if (!is_frag) out_q <= quick;
    end
    if (state_q == S_SCAN) begin
      if (sr.hit) begin
        match_q  <= idx_q;
        have_m_q <= have_q[idx_q];
        len1_m_q <= len1_q[idx_q];
        len2_m_q <= len2_q[idx_q];
      end
      if (sr.take_spare) begin
        spare_q       <= idx_q;
        spare_busy_q  <= sr.busy_after;
        spare_start_q <= start_q[idx_q];
      end
    end
    if (state_q == S_UPDATE) begin
      // fresh slot: key it to this sender, tag and time
      if (!match_v_q) begin
        sender_q[s_idx] <= item_q.sender_node;
        tag_q[s_idx]    <= item_q.pair_tag;
        start_q[s_idx]  <= item_q.now_ms;
      end
      have_q[s_idx] <= have_new;
      len1_q[s_idx] <= p1;
      len2_q[s_idx] <= p2;
      out_q         <= upd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/core/frs_cfg_regs.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// frs_cfg_regs
// APB-style register file for timeout and length limits.
// ---------------------------------------------------------------------------
module frs_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [frs_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output frs_pkg::cfg_t                   cfg_o
);
  import frs_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fragment_timeout_ms <= RST_TIMEOUT;
      cfg_q.output_capacity     <= RST_CAPACITY;
      cfg_q.max_message_len     <= RST_MAX_MSG;
      cfg_q.max_fragment_data   <= RST_MAX_FRAG;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TIMEOUT:  cfg_q.fragment_timeout_ms <= pwdata[30:0];
        REG_CAPACITY: cfg_q.output_capacity     <= pwdata[9:0];
        REG_MAX_MSG:  cfg_q.max_message_len     <= pwdata[8:0];
        REG_MAX_FRAG: cfg_q.max_fragment_data   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT:  prdata = {1'b0, cfg_q.fragment_timeout_ms};
      REG_CAPACITY: prdata = {22'd0, cfg_q.output_capacity};
      REG_MAX_MSG:  prdata = {23'd0, cfg_q.max_message_len};
      REG_MAX_FRAG: prdata = {24'd0, cfg_q.max_fragment_data};
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/frs_scan_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// frs_scan_unit
// Per-slot evaluation: timeout, key match and oldest/free spare choice.
// ---------------------------------------------------------------------------
module frs_scan_unit (
  input  frs_pkg::scan_in_t    slot_i,
  input  logic [30:0]          timeout_i,
  output frs_pkg::scan_res_t   res_o
);
  import frs_pkg::*;

  logic [31:0] age;
  logic [31:0] diff;
  logic        busy_after;

  assign age        = slot_i.now - slot_i.start;
  assign diff       = slot_i.start - slot_i.spare_start;
  // wrapping age counts only while non-negative
  assign res_o.expire = slot_i.busy & ~age[31] & (age[30:0] > timeout_i);
  assign busy_after   = slot_i.busy & ~res_o.expire;
  assign res_o.busy_after = busy_after;
  assign res_o.hit = busy_after & (slot_i.sender == slot_i.key_sender)
                   & (slot_i.tag == slot_i.key_tag);
  // a free spare sticks; a busy spare yields to a free or older slot
  assign res_o.take_spare = slot_i.first
                          | (slot_i.spare_busy & (~busy_after | diff[31]));

endmodule
`default_nettype wire

@@ tb/sv/fragment_reassembly_slots_tb.sv @@
// ---------------------------------------------------------------------------
// fragment_reassembly_slots_tb
// Drives fragment descriptors into the slot table with random gaps and
// stalls, predicts every result word from a behavioral copy of the table,
// and compares the words field by field across several limit settings.
// ---------------------------------------------------------------------------
module fragment_reassembly_slots_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_data_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  fragment_reassembly_slots dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the limit registers and of the slot table
  cfg_t        cfg_shadow;
  logic        tbl_busy   [SLOT_COUNT];
  logic [31:0] tbl_sender [SLOT_COUNT];
  logic [15:0] tbl_tag    [SLOT_COUNT];
  logic [31:0] tbl_start  [SLOT_COUNT];
  logic [1:0]  tbl_have   [SLOT_COUNT];
  logic [7:0]  tbl_len1   [SLOT_COUNT];
  logic [7:0]  tbl_len2   [SLOT_COUNT];

  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  bit in_acc, out_acc;
  bit calm;
  int send_gap, stall_left, hold_left, hold_request;
  int mismatch_count;

  function automatic bit exceeds_limit(int n);
    return n >= int'(cfg_shadow.output_capacity) || n > int'(cfg_shadow.max_message_len);
  endfunction

  function automatic out_word_t predict_reassembly(in_word_t w);
    out_word_t   r;
    logic [1:0]  part;
    logic [31:0] age, diff;
    int          n, hit, spare, s, total;
    r = '0;
    hit = -1;
    spare = -1;
    if (w.byte_count == 0) begin
      r.status = ST_EMPTY;
      return r;
    end
    if (w.first_byte == CHAR_WHOLE) begin
      r.status = exceeds_limit(int'(w.byte_count)) ? ST_LONG : ST_WHOLE;
      r.total_len = {1'b0, w.byte_count};
      return r;
    end
    part = w.first_byte[1:0];
    if (w.first_byte[7:2] != FRAG_MARK || !(part == PART_ONE || part == PART_TWO) ||
        int'(w.byte_count) <= FRAG_HEADER_LEN ||
        int'(w.byte_count) - FRAG_HEADER_LEN > int'(cfg_shadow.max_fragment_data)) begin
      r.status = ST_SHAPE;
      return r;
    end
    n = int'(w.byte_count) - FRAG_HEADER_LEN;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (tbl_busy[i]) begin
        age = w.now_ms - tbl_start[i];
        if (!age[31] && age > {1'b0, cfg_shadow.fragment_timeout_ms}) tbl_busy[i] = 1'b0;
      end
      if (tbl_busy[i] && tbl_sender[i] == w.sender_node && tbl_tag[i] == w.pair_tag) hit = i;
      if (spare < 0) begin
        spare = i;
      end else begin
        // prefer a free slot, else the one that started earliest
        diff = tbl_start[i] - tbl_start[spare];
        if (tbl_busy[spare] && (!tbl_busy[i] || diff[31])) spare = i;
      end
    end

    s = hit;
    if (s < 0) begin
      s = spare;
      tbl_busy[s]   = 1'b1;
      tbl_sender[s] = w.sender_node;
      tbl_tag[s]    = w.pair_tag;
      tbl_start[s]  = w.now_ms;
      tbl_have[s]   = '0;
      tbl_len1[s]   = '0;
      tbl_len2[s]   = '0;
    end
    if (part == PART_ONE) tbl_len1[s] = n[7:0];
    else tbl_len2[s] = n[7:0];
    tbl_have[s] = tbl_have[s] | part;

    r.slot_index     = s[3:0];
    r.part_index     = (part == PART_TWO);
    r.first_part_len = tbl_len1[s];
    if (tbl_have[s] != (PART_ONE | PART_TWO)) begin
      r.status = ST_STORED;
      return r;
    end
    total = int'(tbl_len1[s]) + int'(tbl_len2[s]);
    tbl_busy[s] = 1'b0;
    r.status    = exceeds_limit(total) ? ST_LONG : ST_JOINED;
    r.total_len = total[8:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < 50) $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
  endfunction

  function automatic void push_word(logic [7:0] fb, logic [7:0] len, logic [31:0] sender,
                                    logic [15:0] tag, logic [31:0] stamp);
    in_word_t w;
    w.first_byte  = fb;
    w.byte_count  = len;
    w.sender_node = sender;
    w.pair_tag    = tag;
    w.now_ms      = stamp;
    pending_words.push_back(w);
  endfunction

  // sample both channels; predict on input accept, check on output accept
  always @(posedge clk_i) begin
    out_word_t want;
    if (!rst_ni) begin
      in_acc  = 1'b0;
      out_acc = 1'b0;
    end else begin
      in_acc  = in_valid_i && !in_stall_o;
      out_acc = out_valid_o && !out_stall_i;
      if (in_acc) expected_results.push_back(predict_reassembly(in_data_i));
      if (out_acc) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending: %h", out_data_o));
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(out_data_o.status), 32'(want.status));
          compare_field("slot_index", 32'(out_data_o.slot_index), 32'(want.slot_index));
          compare_field("part_index", 32'(out_data_o.part_index), 32'(want.part_index));
          compare_field("first_part_len", 32'(out_data_o.first_part_len),
                        32'(want.first_part_len));
          compare_field("total_len", 32'(out_data_o.total_len), 32'(want.total_len));
        end
      end
    end
  end

  // sender: hold a stalled word, wait out the drawn gap, then offer the next
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_acc) send_gap = draw_wait();
      if (in_valid_i && !in_acc) begin
        // hold
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_words.size() != 0) begin
        in_data_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall after each word, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (out_acc) stall_left = draw_wait();
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TIMEOUT:  cfg_shadow.fragment_timeout_ms = val[30:0];
      REG_CAPACITY: cfg_shadow.output_capacity     = val[9:0];
      REG_MAX_MSG:  cfg_shadow.max_message_len     = val[8:0];
      REG_MAX_FRAG: cfg_shadow.max_fragment_data   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SLOT_COUNT + 4) @(negedge clk_i);
  endtask

  // mostly well-formed fragments over a small key pool, some whole words, some noise
  task automatic fill_random(int count);
    logic [31:0] senders [3];
    logic [15:0] tags [3];
    logic [31:0] clock_ms;
    in_word_t    w;
    int          kind, lim;
    foreach (senders[i]) senders[i] = $urandom;
    foreach (tags[i]) tags[i] = 16'($urandom_range(0, 65535));
    clock_ms = $urandom_range(0, 3) == 0 ? 32'hFFFF_FF00 : $urandom;
    lim = int'(cfg_shadow.max_fragment_data);
    if (lim > 252) lim = 252;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: clock_ms += cfg_shadow.fragment_timeout_ms + $urandom_range(0, 3);
        1: clock_ms += $urandom;
        default: clock_ms += $urandom_range(0, 40);
      endcase
      w.sender_node = senders[$urandom_range(0, 2)];
      w.pair_tag    = tags[$urandom_range(0, 2)];
      w.now_ms      = clock_ms;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        w.first_byte = {FRAG_MARK, $urandom_range(0, 1) ? PART_ONE : PART_TWO};
        case ($urandom_range(0, 19))
          0: w.byte_count = 8'($urandom_range(0, FRAG_HEADER_LEN));
          1: w.byte_count = 8'($urandom_range(lim + FRAG_HEADER_LEN, 255));
          2: w.byte_count = 8'(lim + FRAG_HEADER_LEN);
          default: w.byte_count = 8'($urandom_range(1, lim) + FRAG_HEADER_LEN);
        endcase
      end else if (kind < 82) begin
        w.first_byte = CHAR_WHOLE;
        w.byte_count = 8'($urandom_range(0, 255));
      end else begin
        w = in_word_t'({$urandom, $urandom, $urandom});
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic run_phase(logic [30:0] tmo, logic [9:0] cap, logic [8:0] mmsg,
                           logic [7:0] mfrag, int count, bit quiet, int burst);
    wait_idle();
    cfg_write(REG_TIMEOUT, 32'(tmo));
    cfg_write(REG_CAPACITY, 32'(cap));
    cfg_write(REG_MAX_MSG, 32'(mmsg));
    cfg_write(REG_MAX_FRAG, 32'(mfrag));
    calm = quiet;
    hold_request = burst;
    fill_random(count);
  endtask

  initial begin
    logic [31:0] src;
    logic [15:0] key;
    cfg_shadow.fragment_timeout_ms = RST_TIMEOUT;
    cfg_shadow.output_capacity     = RST_CAPACITY;
    cfg_shadow.max_message_len     = RST_MAX_MSG;
    cfg_shadow.max_fragment_data   = RST_MAX_FRAG;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_busy[i]   = 1'b0;
      tbl_sender[i] = '0;
      tbl_tag[i]    = '0;
      tbl_start[i]  = '0;
      tbl_have[i]   = '0;
      tbl_len1[i]   = '0;
      tbl_len2[i]   = '0;
    end
    mismatch_count = 0;
    calm = 1'b0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    hold_request = 0;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset limits
    src = 32'hDEAD_BEEF;
    key = 16'hA5A5;
    push_word(CHAR_WHOLE, 8'd0, src, key, 32'd1000);
    push_word({FRAG_MARK, PART_ONE}, 8'd0, src, key, 32'd1000);
    push_word(CHAR_WHOLE, 8'd1, src, key, 32'd1000);
    push_word(CHAR_WHOLE, 8'd255, src, key, 32'd1000);
    push_word(8'h00, 8'd10, src, key, 32'd1000);
    push_word(8'hFF, 8'd10, src, key, 32'd1000);
    push_word(8'h80, 8'd10, src, key, 32'd1000);
    push_word(8'h83, 8'd10, src, key, 32'd1000);
    push_word({FRAG_MARK, PART_ONE}, 8'd3, src, key, 32'd1000);
    push_word({FRAG_MARK, PART_ONE}, 8'd204, src, key, 32'd1000);
    // largest pair joins to exactly the message limit
    push_word({FRAG_MARK, PART_ONE}, 8'd203, src, key, 32'd1000);
    push_word({FRAG_MARK, PART_TWO}, 8'd203, src, key, 32'd1001);
    // second half arrives first
    push_word({FRAG_MARK, PART_TWO}, 8'd13, src, key + 16'd1, 32'd1002);
    push_word({FRAG_MARK, PART_ONE}, 8'd4, src, key + 16'd1, 32'd1003);
    // repeated first half overwrites its length
    push_word({FRAG_MARK, PART_ONE}, 8'd10, src, key + 16'd2, 32'd1004);
    push_word({FRAG_MARK, PART_ONE}, 8'd20, src, key + 16'd2, 32'd1005);
    push_word({FRAG_MARK, PART_TWO}, 8'd5, src, key + 16'd2, 32'd1006);
    // fill every slot, then evict the oldest
    for (int i = 0; i < SLOT_COUNT; i++)
      push_word({FRAG_MARK, PART_ONE}, 8'd9, src, key + 16'd10 + 16'(i), 32'd2000 + 32'(i));
    push_word({FRAG_MARK, PART_ONE}, 8'd9, src, key + 16'd20, 32'd2010);
    // one slot just past the timeout is freed before the search
    push_word({FRAG_MARK, PART_TWO}, 8'd7, src, key + 16'd11, 32'd2001 + 32'd30001);
    // pair across the time wrap
    push_word({FRAG_MARK, PART_ONE}, 8'd50, ~src, key, 32'hFFFF_FFF0);
    push_word({FRAG_MARK, PART_TWO}, 8'd60, ~src, key, 32'h0000_0010);

    run_phase(31'd30000, 10'd512, 9'd400, 8'd200, 150, 1'b0, 0);
    run_phase(31'd0, 10'd1, 9'd1, 8'd1, 100, 1'b0, 0);
    run_phase(31'h7FFF_FFFF, 10'd512, 9'd511, 8'd252, 150, 1'b1, 400);
    run_phase(31'd25, 10'd300, 9'd511, 8'd252, 150, 1'b0, 0);
    run_phase(31'd500, 10'd0, 9'd511, 8'd150, 80, 1'b0, 0);
    run_phase(31'd1000, 10'd512, 9'd250, 8'd252, 150, 1'b0, 250);
    repeat (3)
      run_phase(31'($urandom_range(0, 1) ? $urandom_range(0, 400)
                                         : $urandom_range(0, 32'h7FFF_FFFF)),
                10'($urandom_range(1, 512)), 9'($urandom_range(1, 511)),
                8'($urandom_range(1, 252)), 120, 1'b0, 0);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/frs_pkg.sv
rtl/core/frs_cfg_regs.sv
rtl/core/frs_scan_unit.sv
rtl/core/fragment_reassembly_slots.sv
tb/sv/fragment_reassembly_slots_tb.sv
